@@ rtl/core/scprq_pkg.sv @@
// ----------------------------------------------------------------------------
// scprq_pkg
// Shared sizes, codes and types for the serial command parser and reply queue.
// ----------------------------------------------------------------------------
package scprq_pkg;

    localparam int RING_DEPTH   = 8;
    localparam int CONFIG_BYTES = 128;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int CFG_AW       = $clog2(CONFIG_BYTES);

    typedef logic [2:0] t_event;
    typedef logic [1:0] t_source;
    typedef logic [1:0] t_pwm;
    typedef logic [1:0] t_parse_st;

    // parser states
    localparam t_parse_st ST_CMD    = 2'd0;
    localparam t_parse_st ST_OFFSET = 2'd1;
    localparam t_parse_st ST_VALUE  = 2'd2;

    // event codes
    localparam t_event EV_NONE  = 3'd0;
    localparam t_event EV_WRITE = 3'd1;
    localparam t_event EV_SAVE  = 3'd2;
    localparam t_event EV_STEP  = 3'd3;
    localparam t_event EV_TX    = 3'd4;

    // reply data sources
    localparam t_source SRC_RT      = 2'd0;
    localparam t_source SRC_CLOCK   = 2'd1;
    localparam t_source SRC_VERSION = 2'd2;
    localparam t_source SRC_CONFIG  = 2'd3;

    // PWM update codes
    localparam t_pwm PWM_NONE = 2'd0;
    localparam t_pwm PWM_DUTY = 2'd1;
    localparam t_pwm PWM_DLY  = 2'd2;

    localparam logic [7:0] PWM_DUTY_ADDR = 8'h5F;
    localparam logic [7:0] PWM_DLY_ADDR  = 8'h60;

    // byte count and last byte index of each reply job
    localparam logic [7:0] RT_BYTES = 8'd22;
    localparam logic [7:0] VE_BYTES = 8'h7C;
    localparam logic [7:0] RT_LAST  = RT_BYTES - 8'd1;
    localparam logic [7:0] VE_LAST  = VE_BYTES - 8'd1;
    localparam logic [7:0] ONE_LAST = 8'd0;
    localparam logic [7:0] CFG_LAST = 8'(CONFIG_BYTES - 1);

    // command letters
    localparam logic [7:0] CMD_RT      = 8'h41; // A
    localparam logic [7:0] CMD_SAVE    = 8'h42; // B
    localparam logic [7:0] CMD_CLOCK   = 8'h43; // C
    localparam logic [7:0] CMD_FLUSH   = 8'h46; // F
    localparam logic [7:0] CMD_VERSION = 8'h51; // Q
    localparam logic [7:0] CMD_STEP_UP = 8'h53; // S
    localparam logic [7:0] CMD_TABLE   = 8'h54; // T
    localparam logic [7:0] CMD_VE      = 8'h56; // V
    localparam logic [7:0] CMD_WRITE   = 8'h57; // W
    localparam logic [7:0] CMD_STEP_DN = 8'h73; // s

endpackage

@@ rtl/core/serial_command_parser_reply_queue.sv @@
// ----------------------------------------------------------------------------
// serial_command_parser_reply_queue
// Command parser for received serial bytes with a ring of queued reply jobs.
// ----------------------------------------------------------------------------
// Each request is either a received byte (mode 0) or a transmitter-ready event
// (mode 1). A request is taken every cycle while the result register is free
// or being drained; the result is registered on the accepting edge. Errored
// bytes, and ready events with no queued job, give no result. The config
// store is a 128 x 8 array with a registered read port, read at the job byte
// index on the accepting edge; per-entry valid flops make it read as zero
// after reset, so no clearing pass is needed. o_stall follows i_stall
// whenever a result is held.
module serial_command_parser_reply_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_error,
    output logic                 o_valid,
    input  logic                 i_stall,
    output scprq_pkg::t_event    o_event_res,
    output scprq_pkg::t_source   o_tx_source,
    output logic [7:0]           o_tx_index,
    output logic [7:0]           o_tx_config_byte,
    output logic [7:0]           o_write_addr,
    output logic [7:0]           o_write_data,
    output scprq_pkg::t_pwm      o_pwm_update,
    output logic                 o_step_up,
    output logic                 o_queue_dropped,
    output logic                 o_tx_pending
);
    import scprq_pkg::*;

    // parser and ring state
    t_parse_st            r_parse_st, n_parse_st;
    logic [7:0]           r_pend_off, n_pend_off;
    logic [RING_AW-1:0]   r_head, n_head;
    logic [RING_AW-1:0]   r_tail, n_tail;
    logic [7:0]           r_bcnt, n_bcnt;
    logic                 r_te, n_te;
    t_source              r_job_src  [RING_DEPTH];
    logic [7:0]           r_job_last [RING_DEPTH];

    // config store
    logic [7:0]           r_cfg_mem [CONFIG_BYTES];
    logic [CONFIG_BYTES-1:0] r_cfg_vld;
    logic [7:0]           r_rd_data;
    logic                 r_rd_en;

    // result register
    logic                 r_valid;
    t_event               r_event;
    t_source              r_src;
    logic [7:0]           r_idx;
    logic [7:0]           r_waddr;
    logic [7:0]           r_wdata;
    t_pwm                 r_pwm;
    logic                 r_step_up;
    logic                 r_drop;
    logic                 r_pend;

    logic                 accept;
    logic [RING_AW-1:0]   head_next;
    logic [RING_AW-1:0]   tail_next;
    logic                 ring_full;
    logic                 push_en;
    t_source              push_src;
    logic [7:0]           push_last;
    logic                 mem_we;
    logic                 rd_apply;
    logic                 n_has;
    t_event               n_event;
    t_source              n_src;
    logic [7:0]           n_idx;
    logic [7:0]           n_waddr;
    logic [7:0]           n_wdata;
    t_pwm                 n_pwm;
    logic                 n_step_up;
    logic                 n_drop;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign head_next = (r_head == RING_AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == RING_AW'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign ring_full = (head_next == r_tail);

    always_comb begin
        n_parse_st = r_parse_st;
        n_pend_off = r_pend_off;
        n_head     = r_head;
        n_tail     = r_tail;
        n_bcnt     = r_bcnt;
        n_te       = r_te;
        push_en    = 1'b0;
        push_src   = SRC_RT;
        push_last  = ONE_LAST;
        mem_we     = 1'b0;
        rd_apply   = 1'b0;
        n_has      = 1'b0;
        n_event    = EV_NONE;
        n_src      = SRC_RT;
        n_idx      = '0;
        n_waddr    = '0;
        n_wdata    = '0;
        n_pwm      = PWM_NONE;
        n_step_up  = 1'b0;
        n_drop     = 1'b0;

        if (i_mode) begin
            if (r_te && (r_tail != r_head)) begin
                n_has    = 1'b1;
                n_event  = EV_TX;
                n_src    = r_job_src[r_tail];
                n_idx    = r_bcnt;
                rd_apply = (r_job_src[r_tail] == SRC_CONFIG) &&
                           ({1'b0, r_bcnt} < 9'(CONFIG_BYTES));
                if (r_bcnt < r_job_last[r_tail]) begin
                    n_bcnt = r_bcnt + 8'd1;
                end else begin
                    // retire the job
                    n_bcnt = '0;
                    n_tail = tail_next;
                    if (tail_next == r_head) begin
                        n_te = 1'b0;
                    end
                end
            end
        end else if (!i_rx_error) begin
            n_has = 1'b1;
            unique case (r_parse_st)
                ST_OFFSET: begin
                    n_pend_off = i_rx_byte;
                    n_parse_st = ST_VALUE;
                end
                ST_VALUE: begin
                    n_waddr    = r_pend_off;
                    n_wdata    = i_rx_byte;
                    n_parse_st = ST_CMD;
                    if ({1'b0, r_pend_off} < 9'(CONFIG_BYTES)) begin
                        mem_we  = 1'b1;
                        n_event = EV_WRITE;
                        if (r_pend_off == PWM_DUTY_ADDR) begin
                            n_pwm = PWM_DUTY;
                        end else if (r_pend_off == PWM_DLY_ADDR) begin
                            n_pwm = PWM_DLY;
                        end
                    end
                end
                default: begin
                    n_parse_st = ST_CMD;
                    unique case (i_rx_byte)
                        CMD_RT: begin
                            push_en   = 1'b1;
                            push_src  = SRC_RT;
                            push_last = RT_LAST;
                        end
                        CMD_CLOCK: begin
                            push_en   = 1'b1;
                            push_src  = SRC_CLOCK;
                            push_last = ONE_LAST;
                        end
                        CMD_VERSION: begin
                            push_en   = 1'b1;
                            push_src  = SRC_VERSION;
                            push_last = ONE_LAST;
                        end
                        CMD_TABLE: begin
                            push_en   = 1'b1;
                            push_src  = SRC_CONFIG;
                            push_last = CFG_LAST;
                        end
                        CMD_VE: begin
                            push_en   = 1'b1;
                            push_src  = SRC_CONFIG;
                            push_last = VE_LAST;
                        end
                        CMD_SAVE: begin
                            n_event = EV_SAVE;
                        end
                        CMD_STEP_DN: begin
                            n_event = EV_STEP;
                        end
                        CMD_STEP_UP: begin
                            n_event   = EV_STEP;
                            n_step_up = 1'b1;
                        end
                        CMD_FLUSH: begin
                            n_te   = 1'b0;
                            n_head = '0;
                            n_tail = '0;
                            n_bcnt = '0;
                        end
                        CMD_WRITE: begin
                            n_parse_st = ST_OFFSET;
                        end
                        default: begin
                        end
                    endcase
                end
            endcase

            if (push_en) begin
                if (ring_full) begin
                    // drop the job
                    push_en = 1'b0;
                    n_drop  = 1'b1;
                end else begin
                    n_head = head_next;
                    n_te   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_st <= ST_CMD;
            r_pend_off <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_bcnt     <= '0;
            r_te       <= 1'b0;
            r_cfg_vld  <= '0;
            r_valid    <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_job_src[i]  <= SRC_RT;
                r_job_last[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_parse_st <= n_parse_st;
                r_pend_off <= n_pend_off;
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_bcnt     <= n_bcnt;
                r_te       <= n_te;
                r_valid    <= n_has;
                if (push_en) begin
                    r_job_src[r_head]  <= push_src;
                    r_job_last[r_head] <= push_last;
                end
                if (mem_we) begin
                    r_cfg_vld[r_pend_off[CFG_AW-1:0]] <= 1'b1;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // config store array and registered read port
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_cfg_mem[r_pend_off[CFG_AW-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_cfg_mem[r_bcnt[CFG_AW-1:0]];
            r_rd_en   <= rd_apply && r_cfg_vld[r_bcnt[CFG_AW-1:0]];
            r_event   <= n_event;
            r_src     <= n_src;
            r_idx     <= n_idx;
            r_waddr   <= n_waddr;
            r_wdata   <= n_wdata;
            r_pwm     <= n_pwm;
            r_step_up <= n_step_up;
            r_drop    <= n_drop;
            r_pend    <= n_te;
        end
    end

    assign o_valid          = r_valid;
    assign o_event_res      = r_event;
    assign o_tx_source      = r_src;
    assign o_tx_index       = r_idx;
    assign o_tx_config_byte = r_rd_en ? r_rd_data : 8'd0;
    assign o_write_addr     = r_waddr;
    assign o_write_data     = r_wdata;
    assign o_pwm_update     = r_pwm;
    assign o_step_up        = r_step_up;
    assign o_queue_dropped  = r_drop;
    assign o_tx_pending     = r_pend;

endmodule
